// File: rtl/letc_pkg.sv
// shared constants and types for the exposure time calculator
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package letc_pkg;

  localparam int unsigned MulStages = 3;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned LuxStages = 5;
  localparam int unsigned PipeDepth = MulStages + DivSteps;

  localparam logic [15:0] ExpMax      = 16'hFFFF;
  localparam logic [5:0]  DigitBase   = 6'h30;
  localparam logic [11:0] ExpScale    = 12'd3000;
  // floor(x / 6) == (x * LuxRecip) >> LuxShift for every x below 2^19
  localparam logic [19:0] LuxRecip    = 20'd699051;
  localparam int unsigned LuxShift    = 22;

  localparam logic [15:0] CoefReset   = 16'd256;
  localparam logic [9:0]  ApertReset  = 10'd64;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusSat  = 2'd1,
    StatusDark = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    RegCoef  = 8'd0,
    RegApert = 8'd1,
    RegNd    = 8'd2,
    RegIso   = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] lux;
    logic [5:0]  d10k;
    logic [5:0]  d1k;
    logic [5:0]  d100;
    logic [5:0]  d10;
    logic [5:0]  d1;
  } lux_res_t;

endpackage

// File: rtl/letc_mul.sv
// three-stage product coef * fnum^2 * 3000, scaled down by 2^16
// depends on letc_pkg
`timescale 1ns / 1ps

module letc_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] raw_i,
  input  logic [15:0] coef_i,
  input  logic [9:0]  fnum_i,
  output logic [15:0] raw_o,
  output logic [31:0] num_o
);
  import letc_pkg::*;

  logic [25:0] p1_q;
  logic [35:0] p2_q;
  logic [31:0] n_q;
  logic [15:0] raw1_q, raw2_q, raw3_q;
  logic [47:0] p3;

  assign p3 = 48'(p2_q) * 48'(ExpScale);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= 26'(coef_i) * 26'(fnum_i);
      p2_q   <= 36'(p1_q) * 36'(fnum_i);
      n_q    <= p3[47:16];
      raw1_q <= raw_i;
      raw2_q <= raw1_q;
      raw3_q <= raw2_q;
    end
  end

  assign num_o = n_q;
  assign raw_o = raw3_q;

endmodule

// File: rtl/letc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on letc_pkg
`timescale 1ns / 1ps

module letc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic [31:0] quo_o,
  output logic [15:0] den_o
);
  import letc_pkg::*;

  logic [15:0] rem_q  [DivSteps];
  logic [31:0] work_q [DivSteps];
  logic [15:0] den_q  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [15:0] rem_p, den_p;
    logic [31:0] work_p;
    logic [16:0] t, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign work_p = num_i;
      assign den_p  = den_i;
    end else begin : g_rest
      assign rem_p  = rem_q[k-1];
      assign work_p = work_q[k-1];
      assign den_p  = den_q[k-1];
    end

    assign t    = {rem_p, work_p[31]};
    assign diff = t - {1'b0, den_p};
    assign ge   = (t >= {1'b0, den_p});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[15:0] : t[15:0];
        work_q[k] <= {work_p[30:0], ge};
        den_q[k]  <= den_p;
      end
    end
  end

  assign quo_o = work_q[DivSteps-1];
  assign den_o = den_q[DivSteps-1];

endmodule

// File: rtl/letc_lux.sv
// lux = raw*5/6 and its ascii digits, delayed to match the exposure path
// depends on letc_pkg
`timescale 1ns / 1ps

module letc_lux (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        raw_i,
  output letc_pkg::lux_res_t res_o
);
  import letc_pkg::*;

  localparam int unsigned DelayLen = PipeDepth - LuxStages;
  localparam logic [15:0] Place [4] = '{16'd10000, 16'd1000, 16'd100, 16'd10};

  logic [18:0]  x5;
  logic [38:0]  prod;
  logic [15:0]  rem_q [5];
  logic [5:0]   dig_q [4][4];
  lux_res_t     line_q [DelayLen];
  logic [15:0]  lux_q [5];

  assign x5   = 19'(raw_i) * 19'd5;
  assign prod = 39'(x5) * 39'(LuxRecip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= prod[LuxShift +: 16];
      lux_q[0] <= prod[LuxShift +: 16];
    end
  end

  // one decimal digit per stage; earlier digits ride along
  for (genvar s = 0; s < 4; s++) begin : g_dig
    logic [3:0]  q;
    logic [15:0] r;
    always_comb begin
      q = '0;
      for (int k = 1; k < 10; k++) begin
        // compare at 20 bits, nine times ten thousand does not fit in 16
        if (20'(rem_q[s]) >= 20'(k) * 20'(Place[s])) q = 4'(k);
      end
      r = rem_q[s] - 16'(q) * Place[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r;
        lux_q[s+1] <= lux_q[s];
        for (int j = 0; j < 4; j++) begin
          if (j == s) dig_q[s][j] <= DigitBase + 6'(q);
          else if (j < s) dig_q[s][j] <= dig_q[(s == 0) ? 0 : s-1][j];
        end
      end
    end
  end

  for (genvar i = 0; i < DelayLen; i++) begin : g_line
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (i == 0) begin
          line_q[i] <= '{lux: lux_q[4], d10k: dig_q[3][0], d1k: dig_q[3][1],
                         d100: dig_q[3][2], d10: dig_q[3][3],
                         d1: DigitBase + rem_q[4][5:0]};
        end else begin
          line_q[i] <= line_q[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign res_o = line_q[DelayLen-1];

endmodule

// File: rtl/lux_exposure_time_calculator_top.sv
// top level of the lux and exposure time calculator
// depends on letc_pkg, letc_mul, letc_div, letc_lux
`timescale 1ns / 1ps

// usage
//   input stream: one 16-bit raw sensor count per transfer on s_axis_*
//   output stream: one result per count on m_axis_*, in order; tdata holds
//   lux, five ascii digits and exposure time, tuser holds the status
//   config channel: cfg_valid_i/cfg_index_i/cfg_data_i, always ready;
//   index 0 coefficient, 1 f-number, 2 nd stops, 3 iso shift, others ignored;
//   write only while no result is outstanding
// timing
//   an input transfer passes through 3 multiply stages, 32 divider stages
//   (one quotient bit each) and the output register before output valid
//   throughput is one count per cycle while the output is not stalled; the 32-stage divider sets most of the latency
// reset
//   clears all valid bits and loads the register defaults (coef 1.0, f/4,
//   no nd, no iso shift); pipeline data is not reset
// stalls
//   when the output register holds an untaken result the whole pipeline
//   freezes and s_axis_tready drops; nothing is dropped or repeated
module lux_exposure_time_calculator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] raw_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] lux, [21:16] ten thousands, [27:22] thousands, [33:28] hundreds,
  // [39:34] tens, [45:40] units, [61:46] exposure_ms, [63:62] zero
  output logic [63:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] exposure_status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import letc_pkg::*;

  logic [15:0] coef_q;
  logic [9:0]  fnum_q;
  logic [3:0]  nd_q, iso_q;

  logic             en;
  logic [PipeDepth-1:0] vld_q;
  logic [15:0]      raw_m, den_d;
  logic [31:0]      num_m, quo;
  lux_res_t         lux_res;

  logic [46:0]      shifted;
  logic [15:0]      exp_d;
  status_e          stat_d;

  logic             out_vld_q;
  lux_res_t         out_lux_q;
  logic [15:0]      out_exp_q;
  status_e          out_stat_q;

  // config registers; the user must write them only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
      fnum_q <= ApertReset;
      nd_q   <= '0;
      iso_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCoef:  coef_q <= cfg_data_i;
        RegApert: fnum_q <= cfg_data_i[9:0];
        RegNd:    nd_q   <= cfg_data_i[3:0];
        RegIso:   iso_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output register is blocked
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], s_axis_tvalid};
    end
  end

  letc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (s_axis_tdata),
    .coef_i (coef_q),
    .fnum_i (fnum_q),
    .raw_o  (raw_m),
    .num_o  (num_m)
  );

  letc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_m),
    .den_i (raw_m),
    .quo_o (quo),
    .den_o (den_d)
  );

  letc_lux u_lux (
    .clk_i (clk_i),
    .en_i  (en),
    .raw_i (s_axis_tdata),
    .res_o (lux_res)
  );

  // nd shift left then iso shift right, saturate to 16 bits; a zero raw count reports dark
  always_comb begin
    shifted = (47'(quo) << nd_q) >> iso_q;
    if (den_d == '0) begin
      exp_d  = ExpMax;
      stat_d = StatusDark;
    end else if (shifted[46:16] != '0) begin
      exp_d  = ExpMax;
      stat_d = StatusSat;
    end else begin
      exp_d  = shifted[15:0];
      stat_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[PipeDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_lux_q  <= lux_res;
      out_exp_q  <= exp_d;
      out_stat_q <= stat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_exp_q, out_lux_q.d1, out_lux_q.d10,
                          out_lux_q.d100, out_lux_q.d1k, out_lux_q.d10k,
                          out_lux_q.lux};
  assign m_axis_tuser  = out_stat_q;

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[PipeDepth-1]) |=> m_axis_tvalid)
    else $error("finished item did not reach output register");

  a_dark_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StatusDark) |->
      (m_axis_tdata[61:46] == ExpMax && m_axis_tdata[15:0] == 16'd0))
    else $error("dark result with nonzero lux or exposure not saturated");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StatusSat) |-> m_axis_tdata[61:46] == ExpMax)
    else $error("saturated status without max exposure");
`endif

endmodule
